FILE: sv/lbmtc_pkg.sv
package lbmtc_pkg;

    localparam int FRAC_BITS = 22;
    localparam int FIELD_W   = 24;
    localparam int NUM_DIRS  = 9;
    localparam int DIR_W     = 4;

    localparam int DOT_W     = FIELD_W + 2;
    localparam int SERIES_W  = DOT_W + 2;
    localparam int TPROD_W   = FIELD_W + SERIES_W;
    localparam int WSHIFT_W  = 3;
    localparam int WPROD_W   = TPROD_W + 4;
    localparam int SCALED_W  = WPROD_W - FRAC_BITS;

    // weight denominator 36 = 4 * 9
    localparam int WEIGHT_DEN  = 36;
    localparam int DEN_POW2_LG = 2;
    localparam int DEN_ODD     = WEIGHT_DEN >> DEN_POW2_LG;
    localparam int Z_W         = SCALED_W - DEN_POW2_LG;

    // bias keeps the quotient input non-negative
    localparam int GEQ_BIAS_LG = 27;
    localparam int U_W         = 32;
    localparam logic [U_W-1:0] U_BIAS = U_W'(DEN_ODD) << GEQ_BIAS_LG;

    // floor(u / 9) = (u * RECIP) >> RECIP_SHIFT, exact for all 32-bit u
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 33;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(954437177);
    localparam int QM_W        = U_W + RECIP_W;
    localparam int Q_W         = QM_W - RECIP_SHIFT;

    localparam int GEQ_W    = Q_W + 1;
    localparam int DIFF_W   = GEQ_W + 1;
    localparam int CPROD_W  = FIELD_W + 1 + DIFF_W;
    localparam int CORR_W   = CPROD_W - FRAC_BITS;
    localparam int POST_W   = CORR_W + 1;

    localparam int LANE_DEPTH = 7;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic [FIELD_W-1:0]        rate_t;
    typedef logic [DIR_W-1:0]          dir_t;

    localparam rate_t RELAX_RESET = FIELD_W'(1 << FRAC_BITS);

    localparam dir_t DIR_REST = DIR_W'(0);
    localparam dir_t DIR_PX   = DIR_W'(1);
    localparam dir_t DIR_PY   = DIR_W'(2);
    localparam dir_t DIR_NX   = DIR_W'(3);
    localparam dir_t DIR_NY   = DIR_W'(4);
    localparam dir_t DIR_PXPY = DIR_W'(5);
    localparam dir_t DIR_NXPY = DIR_W'(6);
    localparam dir_t DIR_NXNY = DIR_W'(7);
    localparam dir_t DIR_PXNY = DIR_W'(8);

    // projection of the velocity on the lattice direction
    function automatic logic signed [DOT_W-1:0] dir_dot(dir_t dir, field_t ux, field_t uy);
        logic signed [DOT_W-1:0] x;
        logic signed [DOT_W-1:0] y;
        logic signed [DOT_W-1:0] d;
        x = DOT_W'(ux);
        y = DOT_W'(uy);
        unique case (dir)
            DIR_REST: d = '0;
            DIR_PX:   d = x;
            DIR_PY:   d = y;
            DIR_NX:   d = -x;
            DIR_NY:   d = -y;
            DIR_PXPY: d = x + y;
            DIR_NXPY: d = y - x;
            DIR_NXNY: d = -x - y;
            DIR_PXNY: d = x - y;
            default:  d = '0;
        endcase
        return d;
    endfunction

    // weight numerator 16, 4 or 1 as a left shift
    function automatic logic [WSHIFT_W-1:0] dir_wshift(dir_t dir);
        logic [WSHIFT_W-1:0] s;
        unique case (dir)
            DIR_REST: s = WSHIFT_W'(4);
            DIR_PX, DIR_PY, DIR_NX, DIR_NY: s = WSHIFT_W'(2);
            default:  s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/lbm_thermal_bgk_collision_unit.sv
// channel     direction  signals                                   transaction at
// input       in         start, busy, dist_0..8, vel_x, vel_y,     start && !busy
//                        node_temperature
// result      out        done, post_0..8                           done
// relax_rate  in         cfg_we, cfg_wdata                         cfg_we
//
// one node per cycle; each node's result transaction follows its input
// transaction through the lane pipeline registers: series, temperature
// product, rounding, reciprocal multiply for the divide by 9, difference,
// rate product, saturation
// busy is always low; the result receiver cannot stall
// reset clears the valid pipeline and loads relax_rate with 1.0
module lbm_thermal_bgk_collision_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  lbmtc_pkg::rate_t  cfg_wdata,
    input  lbmtc_pkg::field_t dist_0,
    input  lbmtc_pkg::field_t dist_1,
    input  lbmtc_pkg::field_t dist_2,
    input  lbmtc_pkg::field_t dist_3,
    input  lbmtc_pkg::field_t dist_4,
    input  lbmtc_pkg::field_t dist_5,
    input  lbmtc_pkg::field_t dist_6,
    input  lbmtc_pkg::field_t dist_7,
    input  lbmtc_pkg::field_t dist_8,
    input  lbmtc_pkg::field_t vel_x,
    input  lbmtc_pkg::field_t vel_y,
    input  lbmtc_pkg::field_t node_temperature,
    output logic              done,
    output lbmtc_pkg::field_t post_0,
    output lbmtc_pkg::field_t post_1,
    output lbmtc_pkg::field_t post_2,
    output lbmtc_pkg::field_t post_3,
    output lbmtc_pkg::field_t post_4,
    output lbmtc_pkg::field_t post_5,
    output lbmtc_pkg::field_t post_6,
    output lbmtc_pkg::field_t post_7,
    output lbmtc_pkg::field_t post_8
);

    lbmtc_pkg::rate_t  relax_rate_reg;
    lbmtc_pkg::rate_t  relax_rate_next;
    logic [lbmtc_pkg::LANE_DEPTH-1:0] vld_reg;
    logic [lbmtc_pkg::LANE_DEPTH-1:0] vld_next;
    lbmtc_pkg::field_t dist_in  [lbmtc_pkg::NUM_DIRS];
    lbmtc_pkg::field_t post_out [lbmtc_pkg::NUM_DIRS];

    assign busy = 1'b0;

    always_comb
    begin
        relax_rate_next = cfg_we ? cfg_wdata : relax_rate_reg;
        vld_next        = {vld_reg[lbmtc_pkg::LANE_DEPTH-2:0], start && !busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg <= lbmtc_pkg::RELAX_RESET;
            vld_reg        <= '0;
        end
        else
        begin
            relax_rate_reg <= relax_rate_next;
            vld_reg        <= vld_next;
        end
    end

    assign dist_in[0] = dist_0;
    assign dist_in[1] = dist_1;
    assign dist_in[2] = dist_2;
    assign dist_in[3] = dist_3;
    assign dist_in[4] = dist_4;
    assign dist_in[5] = dist_5;
    assign dist_in[6] = dist_6;
    assign dist_in[7] = dist_7;
    assign dist_in[8] = dist_8;

    // one lane per lattice direction
    for (genvar n = 0; n < lbmtc_pkg::NUM_DIRS; n++)
    begin : g_lane
        lbmtc_lane u_lane (
            .clk      (clk),
            .dir      (lbmtc_pkg::DIR_W'(n)),
            .rate     (relax_rate_reg),
            .dist_val (dist_in[n]),
            .vel_x    (vel_x),
            .vel_y    (vel_y),
            .temp     (node_temperature),
            .post     (post_out[n])
        );
    end

    // merge lane results into one transaction
    assign done   = vld_reg[lbmtc_pkg::LANE_DEPTH-1];
    assign post_0 = post_out[0];
    assign post_1 = post_out[1];
    assign post_2 = post_out[2];
    assign post_3 = post_out[3];
    assign post_4 = post_out[4];
    assign post_5 = post_out[5];
    assign post_6 = post_out[6];
    assign post_7 = post_out[7];
    assign post_8 = post_out[8];

endmodule

FILE: sv/lbmtc_lane.sv
module lbmtc_lane (
    input  logic                   clk,
    input  lbmtc_pkg::dir_t        dir,
    input  lbmtc_pkg::rate_t       rate,
    input  lbmtc_pkg::field_t      dist_val,
    input  lbmtc_pkg::field_t      vel_x,
    input  lbmtc_pkg::field_t      vel_y,
    input  lbmtc_pkg::field_t      temp,
    output lbmtc_pkg::field_t      post
);

    localparam logic signed [lbmtc_pkg::SERIES_W-1:0] SERIES_ONE =
        lbmtc_pkg::SERIES_W'(1 << lbmtc_pkg::FRAC_BITS);
    localparam logic signed [lbmtc_pkg::SCALED_W-1:0] ROUND_DEN =
        lbmtc_pkg::SCALED_W'(lbmtc_pkg::WEIGHT_DEN / 2);
    localparam logic signed [lbmtc_pkg::GEQ_W-1:0] GEQ_BIAS =
        lbmtc_pkg::GEQ_W'(1 << lbmtc_pkg::GEQ_BIAS_LG);
    localparam logic signed [lbmtc_pkg::CPROD_W-1:0] ROUND_F =
        lbmtc_pkg::CPROD_W'(1 << (lbmtc_pkg::FRAC_BITS - 1));
    localparam logic signed [lbmtc_pkg::POST_W-1:0] POST_MAX =
        lbmtc_pkg::POST_W'((1 << (lbmtc_pkg::FIELD_W - 1)) - 1);
    localparam logic signed [lbmtc_pkg::POST_W-1:0] POST_MIN =
        -lbmtc_pkg::POST_W'(1 << (lbmtc_pkg::FIELD_W - 1));

    logic signed [lbmtc_pkg::DOT_W-1:0]    dot;
    logic signed [lbmtc_pkg::SERIES_W-1:0] series_next;
    logic signed [lbmtc_pkg::SERIES_W-1:0] series_reg;
    lbmtc_pkg::field_t                     temp_reg;
    lbmtc_pkg::field_t                     g_reg [lbmtc_pkg::LANE_DEPTH-1];

    logic signed [lbmtc_pkg::TPROD_W-1:0]  tprod_reg;
    logic signed [lbmtc_pkg::WPROD_W-1:0]  wprod;
    logic signed [lbmtc_pkg::SCALED_W-1:0] scaled;
    logic signed [lbmtc_pkg::SCALED_W-1:0] scaled_rnd;
    logic signed [lbmtc_pkg::Z_W-1:0]      z;
    logic [lbmtc_pkg::U_W-1:0]             u_next;
    logic [lbmtc_pkg::U_W-1:0]             u_reg;
    logic [lbmtc_pkg::QM_W-1:0]            qm_reg;
    logic signed [lbmtc_pkg::GEQ_W-1:0]    geq;
    logic signed [lbmtc_pkg::DIFF_W-1:0]   diff_next;
    logic signed [lbmtc_pkg::DIFF_W-1:0]   diff_reg;
    logic signed [lbmtc_pkg::CPROD_W-1:0]  cprod_reg;
    logic signed [lbmtc_pkg::CPROD_W-1:0]  cprod_rnd;
    logic signed [lbmtc_pkg::CORR_W-1:0]   corr;
    logic signed [lbmtc_pkg::POST_W-1:0]   post_full;
    lbmtc_pkg::field_t                     post_next;
    lbmtc_pkg::field_t                     post_reg;

    // series 1 + 3 * (c . u)
    always_comb
    begin
        dot         = lbmtc_pkg::dir_dot(dir, vel_x, vel_y);
        series_next = (lbmtc_pkg::SERIES_W'(dot) <<< 1) + lbmtc_pkg::SERIES_W'(dot)
                      + SERIES_ONE;
    end

    // equilibrium: round(T * series * w / (36 * one))
    always_comb
    begin
        wprod      = lbmtc_pkg::WPROD_W'(tprod_reg) <<< lbmtc_pkg::dir_wshift(dir);
        scaled     = lbmtc_pkg::SCALED_W'(wprod >>> lbmtc_pkg::FRAC_BITS);
        scaled_rnd = scaled + ROUND_DEN;
        z          = lbmtc_pkg::Z_W'(scaled_rnd >>> lbmtc_pkg::DEN_POW2_LG);
        u_next     = unsigned'(lbmtc_pkg::U_W'(z)) + lbmtc_pkg::U_BIAS;
    end

    always_comb
    begin
        geq       = signed'(lbmtc_pkg::GEQ_W'(qm_reg[lbmtc_pkg::QM_W-1:lbmtc_pkg::RECIP_SHIFT]))
                    - GEQ_BIAS;
        diff_next = lbmtc_pkg::DIFF_W'(g_reg[3]) - lbmtc_pkg::DIFF_W'(geq);
    end

    // relaxation and saturation
    always_comb
    begin
        cprod_rnd = cprod_reg + ROUND_F;
        corr      = lbmtc_pkg::CORR_W'(cprod_rnd >>> lbmtc_pkg::FRAC_BITS);
        post_full = lbmtc_pkg::POST_W'(g_reg[5]) - lbmtc_pkg::POST_W'(corr);
        priority if (post_full > POST_MAX)
            post_next = lbmtc_pkg::field_t'(POST_MAX);
        else if (post_full < POST_MIN)
            post_next = lbmtc_pkg::field_t'(POST_MIN);
        else
            post_next = lbmtc_pkg::FIELD_W'(post_full);
    end

    always_ff @(posedge clk)
    begin
        series_reg <= series_next;
        temp_reg   <= temp;
        g_reg[0]   <= dist_val;
        for (int i = 1; i < lbmtc_pkg::LANE_DEPTH - 1; i++)
        begin
            g_reg[i] <= g_reg[i-1];
        end
        tprod_reg  <= lbmtc_pkg::TPROD_W'(temp_reg) * lbmtc_pkg::TPROD_W'(series_reg);
        u_reg      <= u_next;
        qm_reg     <= lbmtc_pkg::QM_W'(u_reg) * lbmtc_pkg::QM_W'(lbmtc_pkg::RECIP);
        diff_reg   <= diff_next;
        cprod_reg  <= lbmtc_pkg::CPROD_W'(signed'({1'b0, rate}))
                      * lbmtc_pkg::CPROD_W'(diff_reg);
        post_reg   <= post_next;
    end

    assign post = post_reg;

endmodule
